// ----- sv/stq_pkg.sv -----
`timescale 1ns / 1ps
package stq_pkg;

  localparam int ID_W      = 4;
  localparam int TIME_W    = 32;
  localparam int RELOAD_W  = 31;
  localparam int FCNT_W    = 5;
  localparam logic [FCNT_W-1:0] MAX_FIRE = 5'd16;

  localparam logic [1:0] OP_SET    = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_CHECK  = 2'd2;

  localparam logic [1:0] CMD_NOP    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_INSERT = 2'd2;

  typedef struct packed {
    logic [1:0]          code;
    logic [ID_W-1:0]     id;
    logic [TIME_W-1:0]   expiry;
    logic [RELOAD_W-1:0] reload;
  } list_cmd_t;

  typedef struct packed {
    logic                head_valid;
    logic [ID_W-1:0]     head_id;
    logic [TIME_W-1:0]   head_expiry;
    logic [RELOAD_W-1:0] head_reload;
  } list_stat_t;

  // a is later than b under wrap-around
  function automatic logic is_after(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] d;
    d = a - b;
    return (d != '0) && !d[TIME_W-1];
  endfunction

endpackage

// ----- sv/stq_if.sv -----
`timescale 1ns / 1ps
interface stq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [3:0]  timer_id;
  logic [30:0] delay_ms;
  logic [30:0] reload_ms;
  logic [31:0] now_ms;
  modport source (output valid, operation, timer_id, delay_ms, reload_ms, now_ms,
                  input ready);
  modport sink (input valid, operation, timer_id, delay_ms, reload_ms, now_ms,
                output ready);
endinterface

interface stq_out_if;
  logic        valid;
  logic        ready;
  logic        fired;
  logic [3:0]  fired_id;
  logic [31:0] fired_expiry;
  logic        rearmed;
  logic        last;
  modport source (output valid, fired, fired_id, fired_expiry, rearmed, last,
                  input ready);
  modport sink (input valid, fired, fired_id, fired_expiry, rearmed, last,
                output ready);
endinterface

// ----- sv/stq_list.sv -----
`timescale 1ns / 1ps
module stq_list
  import stq_pkg::*;
#(
  parameter int NUM_TIMERS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  list_cmd_t  cmd,
  output list_stat_t stat
);

  logic [NUM_TIMERS-1:0] v_r, v_nxt;
  logic [ID_W-1:0]       id_r  [NUM_TIMERS];
  logic [ID_W-1:0]       id_nxt[NUM_TIMERS];
  logic [TIME_W-1:0]     ex_r  [NUM_TIMERS];
  logic [TIME_W-1:0]     ex_nxt[NUM_TIMERS];
  logic [RELOAD_W-1:0]   rl_r  [NUM_TIMERS];
  logic [RELOAD_W-1:0]   rl_nxt[NUM_TIMERS];
  logic [NUM_TIMERS-1:0] gone, stop;

  genvar i;
  generate
    for (i = 0; i < NUM_TIMERS; i++) begin : g_cell
      logic hit, here;
      assign hit = v_r[i] && (id_r[i] == cmd.id);
      assign here = !(v_r[i] && !is_after(ex_r[i], cmd.expiry));
      if (i == 0) begin : g_first
        assign gone[i] = hit;
        assign stop[i] = here;
      end else begin : g_rest
        assign gone[i] = hit | gone[i-1];
        assign stop[i] = here | stop[i-1];
      end

      always_comb begin
        v_nxt[i]  = v_r[i];
        id_nxt[i] = id_r[i];
        ex_nxt[i] = ex_r[i];
        rl_nxt[i] = rl_r[i];
        case (cmd.code)
          CMD_REMOVE: begin
            if (gone[i]) begin
              if (i == NUM_TIMERS - 1) begin
                v_nxt[i] = 1'b0;
              end else begin
                v_nxt[i]  = v_r[(i+1) % NUM_TIMERS];
                id_nxt[i] = id_r[(i+1) % NUM_TIMERS];
                ex_nxt[i] = ex_r[(i+1) % NUM_TIMERS];
                rl_nxt[i] = rl_r[(i+1) % NUM_TIMERS];
              end
            end
          end
          CMD_INSERT: begin
            if (stop[i]) begin
              if (i == 0 || !stop[(i+NUM_TIMERS-1) % NUM_TIMERS]) begin
                v_nxt[i]  = 1'b1;
                id_nxt[i] = cmd.id;
                ex_nxt[i] = cmd.expiry;
                rl_nxt[i] = cmd.reload;
              end else begin
                v_nxt[i]  = v_r[(i+NUM_TIMERS-1) % NUM_TIMERS];
                id_nxt[i] = id_r[(i+NUM_TIMERS-1) % NUM_TIMERS];
                ex_nxt[i] = ex_r[(i+NUM_TIMERS-1) % NUM_TIMERS];
                rl_nxt[i] = rl_r[(i+NUM_TIMERS-1) % NUM_TIMERS];
              end
            end
          end
          default: begin
          end
        endcase
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[i] <= 1'b0;
        end else begin
          v_r[i] <= v_nxt[i];
        end
        id_r[i] <= id_nxt[i];
        ex_r[i] <= ex_nxt[i];
        rl_r[i] <= rl_nxt[i];
      end
    end
  endgenerate

  assign stat.head_valid  = v_r[0];
  assign stat.head_id     = id_r[0];
  assign stat.head_expiry = ex_r[0];
  assign stat.head_reload = rl_r[0];

endmodule

// ----- sv/stq_ctrl.sv -----
`timescale 1ns / 1ps
module stq_ctrl
  import stq_pkg::*;
#(
  parameter int NUM_TIMERS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  stq_in_if.sink     in_ch,
  stq_out_if.source  out_ch,
  output list_cmd_t  cmd,
  input  list_stat_t stat
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RM   = 3'd1;
  localparam logic [2:0] S_INS  = 3'd2;
  localparam logic [2:0] S_ACK  = 3'd3;
  localparam logic [2:0] S_EVAL = 3'd4;
  localparam logic [2:0] S_RE   = 3'd5;

  logic [2:0]          st_r, st_nxt;
  logic [1:0]          op_r;
  logic [ID_W-1:0]     id_r;
  logic [RELOAD_W-1:0] delay_r, reload_r;
  logic [TIME_W-1:0]   now_r;
  logic [FCNT_W-1:0]   n_r, n_nxt;
  logic                pv_r, pv_nxt;
  logic [ID_W-1:0]     pid_r, pid_nxt;
  logic [TIME_W-1:0]   pex_r, pex_nxt;
  logic [RELOAD_W-1:0] prl_r, prl_nxt;
  logic                ov_r, ov_nxt;
  logic                of_r, of_nxt, ore_r, ore_nxt, ol_r, ol_nxt;
  logic [ID_W-1:0]     oid_r, oid_nxt;
  logic [TIME_W-1:0]   oex_r, oex_nxt;
  logic                out_free, id_ok, fire, accept;

  assign out_free = !ov_r || out_ch.ready;
  assign id_ok    = 32'(id_r) < NUM_TIMERS;
  assign fire     = stat.head_valid && !is_after(stat.head_expiry, now_r)
                    && (n_r != MAX_FIRE);
  assign in_ch.ready = (st_r == S_IDLE);
  assign accept   = in_ch.valid && in_ch.ready;

  always_comb begin
    st_nxt  = st_r;
    n_nxt   = n_r;
    pv_nxt  = pv_r;
    pid_nxt = pid_r;
    pex_nxt = pex_r;
    prl_nxt = prl_r;
    ov_nxt  = ov_r && !out_ch.ready;
    of_nxt  = of_r;
    oid_nxt = oid_r;
    oex_nxt = oex_r;
    ore_nxt = ore_r;
    ol_nxt  = ol_r;
    cmd     = '{code: CMD_NOP, id: id_r, expiry: now_r, reload: reload_r};
    case (st_r)
      S_IDLE: begin
        if (accept) begin
          case (in_ch.operation)
            OP_SET, OP_CANCEL: st_nxt = S_RM;
            OP_CHECK: begin
              st_nxt = S_EVAL;
              n_nxt  = '0;
              pv_nxt = 1'b0;
            end
            default: st_nxt = S_ACK;
          endcase
        end
      end
      S_RM: begin
        if (id_ok) cmd.code = CMD_REMOVE;
        st_nxt = (op_r == OP_SET && delay_r != '0 && id_ok) ? S_INS : S_ACK;
      end
      S_INS: begin
        cmd.code   = CMD_INSERT;
        cmd.expiry = now_r + {1'b0, delay_r};
        st_nxt     = S_ACK;
      end
      S_ACK: begin
        if (out_free) begin
          ov_nxt  = 1'b1;
          of_nxt  = 1'b0;
          oid_nxt = '0;
          oex_nxt = '0;
          ore_nxt = 1'b0;
          ol_nxt  = 1'b1;
          st_nxt  = S_IDLE;
        end
      end
      S_EVAL: begin
        if (fire) begin
          if (!pv_r || out_free) begin
            if (pv_r) begin
              ov_nxt  = 1'b1;
              of_nxt  = 1'b1;
              oid_nxt = pid_r;
              oex_nxt = pex_r;
              ore_nxt = prl_r != '0;
              ol_nxt  = 1'b0;
            end
            cmd.code = CMD_REMOVE;
            cmd.id   = stat.head_id;
            pv_nxt   = 1'b1;
            pid_nxt  = stat.head_id;
            pex_nxt  = stat.head_expiry;
            prl_nxt  = stat.head_reload;
            n_nxt    = n_r + 1'b1;
            st_nxt   = S_RE;
          end
        end else if (out_free) begin
          ov_nxt  = 1'b1;
          of_nxt  = pv_r;
          oid_nxt = pv_r ? pid_r : '0;
          oex_nxt = pv_r ? pex_r : '0;
          ore_nxt = pv_r && (prl_r != '0);
          ol_nxt  = 1'b1;
          st_nxt  = S_IDLE;
        end
      end
      S_RE: begin
        if (prl_r != '0) begin
          cmd.code   = CMD_INSERT;
          cmd.id     = pid_r;
          cmd.expiry = now_r + {1'b0, prl_r};
          cmd.reload = prl_r;
        end
        st_nxt = S_EVAL;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
      pv_r <= 1'b0;
      n_r  <= '0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
      pv_r <= pv_nxt;
      n_r  <= n_nxt;
    end
    if (accept) begin
      op_r     <= in_ch.operation;
      id_r     <= in_ch.timer_id;
      delay_r  <= in_ch.delay_ms;
      reload_r <= in_ch.reload_ms;
      now_r    <= in_ch.now_ms;
    end
    pid_r <= pid_nxt;
    pex_r <= pex_nxt;
    prl_r <= prl_nxt;
    of_r  <= of_nxt;
    oid_r <= oid_nxt;
    oex_r <= oex_nxt;
    ore_r <= ore_nxt;
    ol_r  <= ol_nxt;
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.fired        = of_r;
  assign out_ch.fired_id     = oid_r;
  assign out_ch.fired_expiry = oex_r;
  assign out_ch.rearmed      = ore_r;
  assign out_ch.last         = ol_r;

endmodule

// ----- sv/sorted_timer_queue.sv -----
`timescale 1ns / 1ps
// Sorted timer queue. Timers live in a row of list cells kept in expiry order;
// on an insert each cell compares its own expiry with the new one, on a remove
// its own id with the given one, so neither depends on the list length. A set
// or cancel removes the timer, then a set with a nonzero delay inserts it anew;
// a check removes each fired timer and re-inserts it when it has a reload. One
// item is in flight at a time; results stall in an output register.
module sorted_timer_queue
  import stq_pkg::*;
#(
  parameter int NUM_TIMERS = 16
) (
  input logic       clk,
  input logic       rst_n,
  stq_in_if.sink    in_ch,
  stq_out_if.source out_ch
);

  list_cmd_t  cmd;
  list_stat_t stat;

  stq_ctrl #(.NUM_TIMERS(NUM_TIMERS)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cmd(cmd), .stat(stat)
  );

  stq_list #(.NUM_TIMERS(NUM_TIMERS)) u_list (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat)
  );

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken while busy");

  a_ack_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.fired) |-> out_ch.last)
    else $error("non-fired result without last");

  a_ack_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.fired) |-> (out_ch.fired_id == '0 && !out_ch.rearmed))
    else $error("non-fired result carries data");

  a_no_cmd_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (cmd.code == CMD_NOP))
    else $error("list command while idle");

endmodule
